### rtl/assert_macros.svh
// Assertion macros shared by the interpolator RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Clocked property, ignored while reset is asserted.
`define PLI_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);
// Clocked implication: whenever ante holds, cons holds in the same cycle.
`define PLI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define PLI_ASSERT(lbl, clk, rst_n, prop, msg)
`define PLI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### rtl/pli_pkg.sv
// Shared types, constants and the divider step for the interpolator.
// No dependencies; imported by every RTL module.
package pli_pkg;

    localparam int NUM_VERTICES = 4;
    localparam int NUM_SEGMENTS = NUM_VERTICES - 1;
    localparam int COORD_W      = 16;
    localparam int SEG_IDX_W    = 2;
    localparam int CFG_INDEX_W  = 4;
    localparam int PROD_W       = 2 * COORD_W;
    localparam int DIV_STAGES   = 4;
    localparam int DIV_STEPS    = COORD_W / DIV_STAGES;

    typedef logic [COORD_W-1:0]        coord_t;
    typedef logic signed [COORD_W-1:0] level_t;
    typedef coord_t [NUM_VERTICES-1:0] coord_arr_t;
    typedef level_t [NUM_VERTICES-1:0] level_arr_t;
    typedef logic [SEG_IDX_W-1:0]      seg_idx_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_V0_X = 4'd0,
        REG_V0_Y = 4'd1,
        REG_V1_X = 4'd2,
        REG_V1_Y = 4'd3,
        REG_V2_X = 4'd4,
        REG_V2_Y = 4'd5,
        REG_V3_X = 4'd6,
        REG_V3_Y = 4'd7
    } cfg_reg_e;

    // Side information that rides along with each item.
    typedef struct packed {
        logic     hit;
        seg_idx_t idx;
        logic     neg;
        level_t   y0;
    } tag_t;

    // Restoring divider state: partial remainder, dividend bits still to
    // shift in, quotient so far and divisor.
    typedef struct packed {
        coord_t rem;
        coord_t low;
        coord_t quo;
        coord_t dx;
    } div_data_t;

    // One restoring step; rem < dx holds before and after.
    function automatic div_data_t div_step(input div_data_t cur);
        div_data_t          nxt;
        logic [COORD_W:0]   trial;
        logic [COORD_W:0]   diff;
        nxt   = cur;
        trial = {cur.rem, cur.low[COORD_W-1]};
        diff  = trial - {1'b0, cur.dx};
        nxt.low = {cur.low[COORD_W-2:0], 1'b0};
        if (trial >= {1'b0, cur.dx})
        begin
            nxt.rem = diff[COORD_W-1:0];
            nxt.quo = {cur.quo[COORD_W-2:0], 1'b1};
        end
        else
        begin
            nxt.rem = trial[COORD_W-1:0];
            nxt.quo = {cur.quo[COORD_W-2:0], 1'b0};
        end
        return nxt;
    endfunction

endpackage

### rtl/piecewise_linear_interpolator_top.sv
// Piecewise linear interpolator over four configured vertices.
// Depends on pli_pkg, pli_select, pli_mult, pli_div_stage, assert_macros.svh.
//
//   channel   direction  handshake            payload
//   input     in         in_valid / in_stall   length_in
//   output    out        out_valid / out_stall weight_out, in_segment, segment_index
//   config    in         cfg_we                cfg_index, cfg_data
//
// The pipeline is two select stages, one multiply stage, four divider
// stages of four quotient bits each, and the output register.
// One item per cycle is sustained while out_stall is low; the divider pipeline sets the depth.
// Reset clears all valid bits and sets every vertex coordinate to zero.
// A stall holds only the stages that are full; empty stages keep filling.
`include "assert_macros.svh"

module piecewise_linear_interpolator_top import pli_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [COORD_W-1:0]     cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [COORD_W-1:0]     length_in,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic signed [COORD_W-1:0] weight_out,
    output logic                   in_segment,
    output logic [SEG_IDX_W-1:0]   segment_index
);

    coord_arr_t vx_reg;
    level_arr_t vy_reg;

    logic   sel_ready;
    logic   sel_valid;
    tag_t   sel_tag;
    coord_t sel_d;
    coord_t sel_dx;
    coord_t sel_dy_mag;

    logic      div_valid [DIV_STAGES+1];
    logic      div_ready [DIV_STAGES+2];
    tag_t      div_tag   [DIV_STAGES+1];
    div_data_t div_data  [DIV_STAGES+1];

    logic     out_valid_reg;
    level_t   weight_reg;
    logic     in_segment_reg;
    seg_idx_t segment_index_reg;
    logic     out_ready;

    logic signed [COORD_W:0] quo_signed;
    logic signed [COORD_W:0] weight_sum;

    // configuration registers; indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vx_reg <= '0;
            vy_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_V0_X: vx_reg[0] <= cfg_data;
                REG_V0_Y: vy_reg[0] <= cfg_data;
                REG_V1_X: vx_reg[1] <= cfg_data;
                REG_V1_Y: vy_reg[1] <= cfg_data;
                REG_V2_X: vx_reg[2] <= cfg_data;
                REG_V2_Y: vy_reg[2] <= cfg_data;
                REG_V3_X: vx_reg[3] <= cfg_data;
                REG_V3_Y: vy_reg[3] <= cfg_data;
                default:  ;
            endcase
        end
    end

    pli_select u_select (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (in_valid),
        .ready_out (sel_ready),
        .length    (length_in),
        .vx        (vx_reg),
        .vy        (vy_reg),
        .valid_out (sel_valid),
        .ready_in  (div_ready[0]),
        .tag       (sel_tag),
        .d         (sel_d),
        .dx        (sel_dx),
        .dy_mag    (sel_dy_mag)
    );

    assign in_stall = !sel_ready;

    pli_mult u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (sel_valid),
        .ready_out (div_ready[0]),
        .tag_in    (sel_tag),
        .d         (sel_d),
        .dx        (sel_dx),
        .dy_mag    (sel_dy_mag),
        .valid_out (div_valid[0]),
        .ready_in  (div_ready[1]),
        .tag_out   (div_tag[0]),
        .data_out  (div_data[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        pli_div_stage u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (div_valid[g]),
            .ready_out (div_ready[g+1]),
            .tag_in    (div_tag[g]),
            .data_in   (div_data[g]),
            .valid_out (div_valid[g+1]),
            .ready_in  (div_ready[g+2]),
            .tag_out   (div_tag[g+1]),
            .data_out  (div_data[g+1])
        );
    end

    // output register: restore the sign and add the segment base
    assign out_ready = !out_valid_reg || !out_stall;
    assign div_ready[DIV_STAGES+1] = out_ready;

    always_comb
    begin
        quo_signed = div_tag[DIV_STAGES].neg ? -$signed({1'b0, div_data[DIV_STAGES].quo})
                                              : $signed({1'b0, div_data[DIV_STAGES].quo});
        weight_sum = $signed({div_tag[DIV_STAGES].y0[COORD_W-1], div_tag[DIV_STAGES].y0})
                     + quo_signed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= div_valid[DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready)
        begin
            weight_reg        <= weight_sum[COORD_W-1:0];
            in_segment_reg    <= div_tag[DIV_STAGES].hit;
            segment_index_reg <= div_tag[DIV_STAGES].idx;
        end
    end

    assign out_valid     = out_valid_reg;
    assign weight_out    = weight_reg;
    assign in_segment    = in_segment_reg;
    assign segment_index = segment_index_reg;

    `PLI_ASSERT_IMPL(a_miss_is_zero, clk, rst_n, out_valid_reg && !in_segment_reg,
        weight_reg == '0 && segment_index_reg == '0, "miss must give zero weight and index")
    `PLI_ASSERT_IMPL(a_index_in_range, clk, rst_n, out_valid_reg && in_segment_reg,
        segment_index_reg != 2'd3, "segment index past last segment")
    `PLI_ASSERT(a_no_accept_when_full, clk, rst_n,
        in_stall |-> (div_valid[0] || sel_valid), "input stalled with an empty select stage")

endmodule

### rtl/pli_select.sv
// Segment search and operand preparation: two pipeline stages.
// Depends on pli_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pli_select import pli_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       valid_in,
    output logic       ready_out,
    input  coord_t     length,
    input  coord_arr_t vx,
    input  level_arr_t vy,
    output logic       valid_out,
    input  logic       ready_in,
    output tag_t       tag,
    output coord_t     d,
    output coord_t     dx,
    output coord_t     dy_mag
);

    // stage 1: segment match
    logic     s1_valid_reg;
    logic     s1_hit_reg;
    seg_idx_t s1_idx_reg;
    coord_t   s1_len_reg;
    coord_t   s1_x0_reg;
    coord_t   s1_x1_reg;
    level_t   s1_y0_reg;
    level_t   s1_y1_reg;

    logic     s1_hit_next;
    seg_idx_t s1_idx_next;
    logic     s1_ready;

    // stage 2: differences
    logic   s2_valid_reg;
    tag_t   s2_tag_reg;
    coord_t s2_d_reg;
    coord_t s2_dx_reg;
    coord_t s2_dy_mag_reg;

    tag_t                s2_tag_next;
    coord_t              s2_d_next;
    coord_t              s2_dx_next;
    coord_t              s2_dy_mag_next;
    logic signed [COORD_W:0] dy;
    logic signed [COORD_W:0] dy_abs;
    logic                s2_ready;

    assign s2_ready  = !s2_valid_reg || ready_in;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign ready_out = s1_ready;

    // Scan from the top so the lowest matching segment wins.
    always_comb
    begin
        s1_hit_next = 1'b0;
        s1_idx_next = '0;
        for (int i = NUM_SEGMENTS - 1; i >= 0; i--)
        begin
            if (length > vx[i] && length < vx[i+1])
            begin
                s1_hit_next = 1'b1;
                s1_idx_next = seg_idx_t'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_hit_reg <= s1_hit_next;
            s1_idx_reg <= s1_idx_next;
            s1_len_reg <= length;
            s1_x0_reg  <= vx[s1_idx_next];
            s1_x1_reg  <= vx[s1_idx_next + 1'b1];
            s1_y0_reg  <= vy[s1_idx_next];
            s1_y1_reg  <= vy[s1_idx_next + 1'b1];
        end
    end

    // A miss becomes 0 * 0 / 1 + 0 so the rest of the pipe needs no bypass.
    always_comb
    begin
        dy     = {s1_y1_reg[COORD_W-1], s1_y1_reg} - {s1_y0_reg[COORD_W-1], s1_y0_reg};
        dy_abs = dy[COORD_W] ? -dy : dy;
        s2_tag_next.hit = s1_hit_reg;
        s2_tag_next.idx = s1_hit_reg ? s1_idx_reg : '0;
        if (s1_hit_reg)
        begin
            s2_tag_next.neg = dy[COORD_W];
            s2_tag_next.y0  = s1_y0_reg;
            s2_d_next       = s1_len_reg - s1_x0_reg;
            s2_dx_next      = s1_x1_reg - s1_x0_reg;
            s2_dy_mag_next  = dy_abs[COORD_W-1:0];
        end
        else
        begin
            s2_tag_next.neg = 1'b0;
            s2_tag_next.y0  = '0;
            s2_d_next       = '0;
            s2_dx_next      = coord_t'(1);
            s2_dy_mag_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready)
        begin
            s2_tag_reg    <= s2_tag_next;
            s2_d_reg      <= s2_d_next;
            s2_dx_reg     <= s2_dx_next;
            s2_dy_mag_reg <= s2_dy_mag_next;
        end
    end

    assign valid_out = s2_valid_reg;
    assign tag       = s2_tag_reg;
    assign d         = s2_d_reg;
    assign dx        = s2_dx_reg;
    assign dy_mag    = s2_dy_mag_reg;

    `PLI_ASSERT_IMPL(a_hit_encloses, clk, rst_n, s1_valid_reg && s1_hit_reg,
        s1_len_reg > s1_x0_reg && s1_len_reg < s1_x1_reg, "matched segment does not enclose length")
    `PLI_ASSERT_IMPL(a_offset_below_span, clk, rst_n, s2_valid_reg,
        s2_d_reg < s2_dx_reg && s2_dx_reg != '0, "offset not below segment span")

endmodule

### rtl/pli_mult.sv
// Product stage: offset times slope magnitude, loaded into divider form.
// Depends on pli_pkg.
module pli_mult import pli_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      valid_in,
    output logic      ready_out,
    input  tag_t      tag_in,
    input  coord_t    d,
    input  coord_t    dx,
    input  coord_t    dy_mag,
    output logic      valid_out,
    input  logic      ready_in,
    output tag_t      tag_out,
    output div_data_t data_out
);

    logic              valid_reg;
    tag_t              tag_reg;
    logic [PROD_W-1:0] prod_reg;
    coord_t            dx_reg;

    assign ready_out = !valid_reg || ready_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_out)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_out)
        begin
            tag_reg  <= tag_in;
            prod_reg <= d * dy_mag;
            dx_reg   <= dx;
        end
    end

    // Upper half is already below dx since the offset is below the span.
    always_comb
    begin
        data_out.rem = prod_reg[PROD_W-1:COORD_W];
        data_out.low = prod_reg[COORD_W-1:0];
        data_out.quo = '0;
        data_out.dx  = dx_reg;
    end

    assign valid_out = valid_reg;
    assign tag_out   = tag_reg;

endmodule

### rtl/pli_div_stage.sv
// One divider stage: a few restoring steps on the magnitude, then a register.
// Depends on pli_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pli_div_stage import pli_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      valid_in,
    output logic      ready_out,
    input  tag_t      tag_in,
    input  div_data_t data_in,
    output logic      valid_out,
    input  logic      ready_in,
    output tag_t      tag_out,
    output div_data_t data_out
);

    logic      valid_reg;
    tag_t      tag_reg;
    div_data_t data_reg;
    div_data_t data_next;

    assign ready_out = !valid_reg || ready_in;

    always_comb
    begin
        data_next = data_in;
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            data_next = div_step(data_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_out)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_out)
        begin
            tag_reg  <= tag_in;
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign tag_out   = tag_reg;
    assign data_out  = data_reg;

    `PLI_ASSERT_IMPL(a_rem_below_divisor, clk, rst_n, valid_reg,
        data_reg.rem < data_reg.dx, "partial remainder not below divisor")

endmodule

### tb/sv/tb.sv
// Self-checking testbench for piecewise_linear_interpolator_top.
// Needs pli_pkg; predicts each weight from its own vertex copy and checks
// every result in order under random input gaps and output stalls.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pli_pkg::*;

    localparam int PIPE_LATENCY  = 8;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 115;
    localparam int LONG_HOLD     = 150;

    typedef enum int {SHAPE_SORTED, SHAPE_SCRAMBLED, SHAPE_NARROW, SHAPE_EXTREME} shape_e;

    typedef struct {
        level_t   weight;
        logic     hit;
        seg_idx_t seg;
    } weight_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [COORD_W-1:0]     cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [COORD_W-1:0]     length_in = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b1;
    logic signed [COORD_W-1:0] weight_out;
    logic                   in_segment;
    logic [SEG_IDX_W-1:0]   segment_index;

    // vertex copy used for prediction
    coord_t vert_x [NUM_VERTICES];
    level_t vert_y [NUM_VERTICES];

    coord_t         length_q[$];
    weight_result_t weight_q[$];

    int errors = 0;
    int items_sent = 0;
    int results_checked = 0;
    int outside_count = 0;
    int settings_used = 0;
    int seg_hits [NUM_SEGMENTS];

    piecewise_linear_interpolator_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .length_in     (length_in),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .weight_out    (weight_out),
        .in_segment    (in_segment),
        .segment_index (segment_index)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // First strictly enclosing segment wins; quotient truncates toward zero.
    function automatic weight_result_t interpolate(input coord_t len);
        weight_result_t r;
        longint         dx;
        longint         dy;
        longint         num;
        r.weight = '0;
        r.hit    = 1'b0;
        r.seg    = '0;
        for (int s = 0; s < NUM_SEGMENTS; s++)
        begin
            if (!r.hit && len > vert_x[s] && len < vert_x[s+1])
            begin
                dx  = longint'(vert_x[s+1]) - longint'(vert_x[s]);
                dy  = longint'(vert_y[s+1]) - longint'(vert_y[s]);
                num = (longint'(len) - longint'(vert_x[s])) * dy;
                r.weight = level_t'(longint'(vert_y[s]) + num / dx);
                r.hit    = 1'b1;
                r.seg    = seg_idx_t'(s);
            end
        end
        return r;
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input coord_t val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_V0_X: vert_x[0] = val;
            REG_V0_Y: vert_y[0] = level_t'(val);
            REG_V1_X: vert_x[1] = val;
            REG_V1_Y: vert_y[1] = level_t'(val);
            REG_V2_X: vert_x[2] = val;
            REG_V2_Y: vert_y[2] = level_t'(val);
            REG_V3_X: vert_x[3] = val;
            REG_V3_Y: vert_y[3] = level_t'(val);
            default: ;
        endcase
    endtask

    task automatic load_vertices(input coord_t x0, input coord_t x1, input coord_t x2,
                                 input coord_t x3, input level_t y0, input level_t y1,
                                 input level_t y2, input level_t y3);
        write_reg(REG_V0_X, x0);
        write_reg(REG_V0_Y, y0);
        write_reg(REG_V1_X, x1);
        write_reg(REG_V1_Y, y1);
        write_reg(REG_V2_X, x2);
        write_reg(REG_V2_Y, y2);
        write_reg(REG_V3_X, x3);
        write_reg(REG_V3_Y, y3);
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic random_vertices();
        coord_t xs[$];
        level_t ys [NUM_VERTICES];
        shape_e shape;
        coord_t base;
        shape = shape_e'($urandom_range(0, 3));
        base  = coord_t'($urandom_range(0, 65535 - 12));
        for (int v = 0; v < NUM_VERTICES; v++)
        begin
            ys[v] = level_t'($urandom);
            case (shape)
                SHAPE_NARROW:
                begin
                    // tiny spans, empty segments included
                    base = base + coord_t'($urandom_range(0, 3));
                    xs.push_back(base);
                end
                SHAPE_EXTREME:
                begin
                    case ($urandom_range(0, 2))
                        0: xs.push_back('0);
                        1: xs.push_back('1);
                        default: xs.push_back(coord_t'($urandom));
                    endcase
                    case ($urandom_range(0, 2))
                        0: ys[v] = level_t'(-32768);
                        1: ys[v] = level_t'(32767);
                        default: ;
                    endcase
                end
                default: xs.push_back(coord_t'($urandom));
            endcase
        end
        if (shape == SHAPE_SORTED)
            xs.sort();
        load_vertices(xs[0], xs[1], xs[2], xs[3], ys[0], ys[1], ys[2], ys[3]);
    endtask

    // Bias toward the span covered by the vertices, and onto the vertices.
    function automatic coord_t pick_length();
        coord_t lo;
        coord_t hi;
        int     pick;
        lo = vert_x[0];
        hi = vert_x[0];
        for (int v = 1; v < NUM_VERTICES; v++)
        begin
            if (vert_x[v] < lo)
                lo = vert_x[v];
            if (vert_x[v] > hi)
                hi = vert_x[v];
        end
        pick = $urandom_range(0, 9);
        if (pick <= 5)
            return coord_t'($urandom_range(hi, lo));
        else if (pick == 6)
            return coord_t'(vert_x[$urandom_range(0, NUM_VERTICES - 1)] + $urandom_range(0, 2) - 1);
        else
            return coord_t'($urandom);
    endfunction

    task automatic wait_idle();
        @(negedge clk);
        while (length_q.size() != 0 || in_valid || weight_q.size() != 0)
            @(negedge clk);
        repeat (PIPE_LATENCY + 2) @(negedge clk);
    endtask

    // Sender: present queued lengths with random gaps between items.
    always @(posedge clk or negedge rst_n)
    begin : length_driver
        int send_gap;
        bit calm;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            length_in <= '0;
            send_gap  = 0;
            calm      = 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                weight_q.push_back(interpolate(length_in));
                items_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (length_q.size() != 0)
                begin
                    length_in <= length_q.pop_front();
                    in_valid  <= 1'b1;
                    if ($urandom_range(0, 63) == 0)
                        calm = !calm;
                    send_gap = calm ? 0 : $urandom_range(0, 11);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: check each result, then stall a random number of cycles.
    always @(posedge clk or negedge rst_n)
    begin : weight_monitor
        weight_result_t exp_r;
        int stall_left;
        int hold_left;
        bit calm;
        if (!rst_n)
        begin
            out_stall  <= 1'b1;
            stall_left = 0;
            hold_left  = 0;
            calm       = 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (weight_q.size() == 0)
                begin
                    $display("%0t: result with no item pending: weight %0d in_segment %0b",
                             $time, weight_out, in_segment);
                    errors++;
                end
                else
                begin
                    exp_r = weight_q.pop_front();
                    if (weight_out !== exp_r.weight)
                    begin
                        $display("%0t: weight_out expected %0d got %0d",
                                 $time, exp_r.weight, weight_out);
                        errors++;
                    end
                    if (in_segment !== exp_r.hit)
                    begin
                        $display("%0t: in_segment expected %0b got %0b",
                                 $time, exp_r.hit, in_segment);
                        errors++;
                    end
                    if (segment_index !== exp_r.seg)
                    begin
                        $display("%0t: segment_index expected %0d got %0d",
                                 $time, exp_r.seg, segment_index);
                        errors++;
                    end
                    if (exp_r.hit)
                        seg_hits[exp_r.seg]++;
                    else
                        outside_count++;
                end
                results_checked++;
                // hold off long enough for the pipeline to back up into the input
                if (results_checked == 200 || results_checked == 700)
                    hold_left = LONG_HOLD;
                if ($urandom_range(0, 63) == 0)
                    calm = !calm;
                stall_left = calm ? 0 : $urandom_range(0, 11);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        #5ms;
        $display("piecewise_linear_interpolator_top test failed");
        $finish;
    end

    initial
    begin
        for (int v = 0; v < NUM_VERTICES; v++)
        begin
            vert_x[v] = '0;
            vert_y[v] = '0;
        end
        for (int s = 0; s < NUM_SEGMENTS; s++)
            seg_hits[s] = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // all vertices at zero after reset: nothing can be enclosed
        @(negedge clk);
        length_q.push_back(16'h0000);
        length_q.push_back(16'h0080);
        length_q.push_back(16'hFFFF);
        wait_idle();

        // plain trapezoid, lengths below, on, between and above the vertices
        load_vertices(16'h0100, 16'h0400, 16'h0800, 16'h0C00,
                      16'sh0000, 16'sh0100, 16'sh0100, 16'sh0000);
        // writes past the last register must leave the vertices alone
        for (int k = 2 * NUM_VERTICES; k < 2 ** CFG_INDEX_W; k++)
            write_reg(CFG_INDEX_W'(k), coord_t'($urandom));
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        length_q.push_back(16'h0000);
        length_q.push_back(16'h0100);
        length_q.push_back(16'h0101);
        length_q.push_back(16'h0200);
        length_q.push_back(16'h0400);
        length_q.push_back(16'h0600);
        length_q.push_back(16'h0A00);
        length_q.push_back(16'h0BFF);
        length_q.push_back(16'h0C00);
        length_q.push_back(16'hFFFF);
        wait_idle();

        // widest span and full-scale weight swing
        load_vertices(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                      16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
        @(negedge clk);
        length_q.push_back(16'h0001);
        length_q.push_back(16'h8000);
        length_q.push_back(16'hFFFE);
        wait_idle();

        // out-of-order vertices: overlapping segments, lowest index wins
        load_vertices(16'h0100, 16'h0900, 16'h0200, 16'h0800,
                      16'sh7FFF, 16'sh8000, 16'sh0100, -16'sh0100);
        @(negedge clk);
        length_q.push_back(16'h0180);
        length_q.push_back(16'h0400);
        length_q.push_back(16'h0880);
        wait_idle();

        // unit steps and an empty middle segment
        load_vertices(16'h1000, 16'h1002, 16'h1002, 16'h1004,
                      16'sd5, -16'sd7, 16'sd3, 16'sd100);
        @(negedge clk);
        length_q.push_back(16'h1001);
        length_q.push_back(16'h1002);
        length_q.push_back(16'h1003);
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            random_vertices();
            @(negedge clk);
            repeat (PHASE_ITEMS) length_q.push_back(pick_length());
            wait_idle();
        end

        if (weight_q.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, weight_q.size());
            errors++;
        end
        $display("Sent %0d lengths across %0d vertex settings, %0d results checked.",
                 items_sent, settings_used, results_checked);
        $display("Hits in segments 0/1/2: %0d/%0d/%0d, outside every segment: %0d.",
                 seg_hits[0], seg_hits[1], seg_hits[2], outside_count);
        if (errors == 0)
            $display("piecewise_linear_interpolator_top test passed");
        else
            $display("piecewise_linear_interpolator_top test failed");
        $finish;
    end

endmodule
